// ===== rtl/ddd_pkg.sv =====
// Shared constants, types and calendar tables for the date difference block.
package ddd_pkg;

	localparam int unsigned YEAR_W = 14;
	localparam int unsigned DN_W   = 22;
	localparam int unsigned DIFF_W = 23;

	localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;

	// floor(v / 100) == (v * DIV100_MUL) >> DIV100_SHIFT for v below 43699
	localparam logic [12:0] DIV100_MUL   = 13'd5243;
	localparam int unsigned DIV100_SHIFT = 19;
	localparam int unsigned PROD_W       = 27;

	localparam logic [3:0] MONTH_JAN = 4'd0;
	localparam logic [3:0] MONTH_FEB = 4'd1;
	localparam logic [3:0] MONTH_DEC = 4'd11;

	typedef logic [YEAR_W-1:0] year_t;
	typedef logic [DN_W-1:0]   day_num_t;
	typedef logic [PROD_W-1:0] prod_t;

	function automatic logic [4:0] month_len(input logic [3:0] mi);
		logic [4:0] len;
		unique case (mi)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
			4'd1:                                      len = 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
			default:                                   len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] mi);
		logic [8:0] d;
		unique case (mi)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/ddd_day_number.sv =====
// Three-stage pipeline from a raw date to its day number counted from 1 January of year zero.
module ddd_day_number
	import ddd_pkg::*;
(
	input  logic              clk,
	input  year_t             year,
	input  logic signed [7:0] month,
	input  logic signed [7:0] day,
	output day_num_t          day_num
);

	year_t      y_c;
	logic [3:0] mi_c;
	logic [6:0] d_c;
	year_t      y99_c;
	year_t      y399_c;
	prod_t      p100_c;
	prod_t      p99_c;
	prod_t      p399_c;

	year_t      y_s1;
	logic [3:0] mi_s1;
	logic [6:0] d_s1;
	prod_t      p100_s1;
	prod_t      p99_s1;
	prod_t      p399_s1;

	logic [6:0]  q100;
	logic [6:0]  q99;
	logic [6:0]  q399;
	logic        div100;
	logic        leap;
	year_t       y3;
	logic [11:0] leaps;
	logic [4:0]  len;
	logic [4:0]  dd;
	logic [8:0]  doy;

	year_t       y_s2;
	logic [11:0] leaps_s2;
	logic [8:0]  doy_s2;

	day_num_t    day_num_s3;

	// clamp and start the divisions by 100
	always_comb begin
		y_c = (year > MAX_YEAR) ? MAX_YEAR : year;
		if (month > 8'sd12) begin
			mi_c = MONTH_DEC;
		end else if (month < 8'sd1) begin
			mi_c = MONTH_JAN;
		end else begin
			mi_c = month[3:0] - 4'd1;
		end
		d_c    = (day < 8'sd1) ? 7'd1 : day[6:0];
		y99_c  = y_c + 14'd99;
		y399_c = y_c + 14'd399;
		p100_c = PROD_W'(y_c) * PROD_W'(DIV100_MUL);
		p99_c  = PROD_W'(y99_c) * PROD_W'(DIV100_MUL);
		p399_c = PROD_W'(y399_c[YEAR_W-1:2]) * PROD_W'(DIV100_MUL);
	end

	always_ff @(posedge clk) begin
		y_s1    <= y_c;
		mi_s1   <= mi_c;
		d_s1    <= d_c;
		p100_s1 <= p100_c;
		p99_s1  <= p99_c;
		p399_s1 <= p399_c;
	end

	// leap rule, leap count and day of year
	always_comb begin
		q100   = p100_s1[DIV100_SHIFT+6:DIV100_SHIFT];
		q99    = p99_s1[DIV100_SHIFT+6:DIV100_SHIFT];
		q399   = p399_s1[DIV100_SHIFT+6:DIV100_SHIFT];
		div100 = (y_s1 == (YEAR_W'(q100) * 14'd100));
		leap   = (y_s1[1:0] == 2'd0) && (!div100 || (q100[1:0] == 2'd0));
		y3     = y_s1 + 14'd3;
		leaps  = 12'(y3[YEAR_W-1:2]) - 12'(q99) + 12'(q399);
		len    = month_len(mi_s1) + 5'((mi_s1 == MONTH_FEB) && leap);
		dd     = (d_s1 > 7'(len)) ? len : d_s1[4:0];
		doy    = days_before(mi_s1) + 9'((mi_s1 > MONTH_FEB) && leap) + 9'(dd) - 9'd1;
	end

	always_ff @(posedge clk) begin
		y_s2     <= y_s1;
		leaps_s2 <= leaps;
		doy_s2   <= doy;
	end

	always_ff @(posedge clk) begin
		day_num_s3 <= DN_W'(y_s2) * 22'd365 + DN_W'(leaps_s2) + DN_W'(doy_s2);
	end

	assign day_num = day_num_s3;

endmodule

// ===== rtl/date_difference_in_days_top.sv =====
// Top level of the Gregorian date difference pipeline.
// A pair of dates is taken on every cycle that start is high; busy stays low. Each pair gives
// one result, shown for one cycle with done high: three stages turn each date
// into a day number (clamp and reciprocal multiply, leap rule and day of year, multiply by 365),
// one stage subtracts and one forms the magnitude and the sign flag. Results cannot be held off,
// so the receiver must take each one in the cycle that done is high.
module date_difference_in_days_top
	import ddd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  year_t                    year_a,
	input  logic signed [7:0]        month_a,
	input  logic signed [7:0]        day_a,
	input  year_t                    year_b,
	input  logic signed [7:0]        month_b,
	input  logic signed [7:0]        day_b,
	output logic                     done,
	output logic signed [DIFF_W-1:0] signed_days,
	output logic [DN_W-1:0]          abs_days,
	output logic                     a_earlier
);

	day_num_t dn_a;
	day_num_t dn_b;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [DIFF_W-1:0] diff_s4;
	logic signed [DIFF_W-1:0] diff_s5;
	logic [DN_W-1:0]          abs_s5;
	logic                     neg_s5;
	logic signed [DIFF_W-1:0] neg_diff;

	ddd_day_number u_dn_a (
		.clk     (clk),
		.year    (year_a),
		.month   (month_a),
		.day     (day_a),
		.day_num (dn_a)
	);

	ddd_day_number u_dn_b (
		.clk     (clk),
		.year    (year_b),
		.month   (month_b),
		.day     (day_b),
		.day_num (dn_b)
	);

	// advance the valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign neg_diff = -diff_s4;

	always_ff @(posedge clk) begin
		diff_s4 <= DIFF_W'({1'b0, dn_a}) - DIFF_W'({1'b0, dn_b});
		diff_s5 <= diff_s4;
		neg_s5  <= diff_s4[DIFF_W-1];
		abs_s5  <= diff_s4[DIFF_W-1] ? neg_diff[DN_W-1:0] : diff_s4[DN_W-1:0];
	end

	assign busy        = 1'b0;
	assign done        = v_s5;
	assign signed_days = diff_s5;
	assign abs_days    = abs_s5;
	assign a_earlier   = neg_s5;

	a_flag_sign: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (a_earlier == signed_days[DIFF_W-1]))
		else $error("a_earlier disagrees with sign of signed_days");

	a_abs_match: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (abs_days == (a_earlier ? DN_W'(-signed_days) : DN_W'(signed_days))))
		else $error("abs_days is not the magnitude of signed_days");

	a_zero_match: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((signed_days == '0) == (abs_days == '0)))
		else $error("zero difference mismatch");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |=> ##1 done)
		else $error("transfer lost between day number and result");

endmodule

// ===== bench/tb.sv =====
// Testbench for the date difference block: reference calculation, checker, directed and random pairs.
`timescale 1ns / 1ps

module tb;
	import ddd_pkg::*;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned ITEMS_PER_PHASE = 317;

	typedef struct {
		year_t             year_a;
		logic signed [7:0] month_a;
		logic signed [7:0] day_a;
		year_t             year_b;
		logic signed [7:0] month_b;
		logic signed [7:0] day_b;
	} date_pair_t;

	typedef struct {
		logic signed [DIFF_W-1:0] signed_days;
		logic [DN_W-1:0]          abs_days;
		logic                     a_earlier;
	} day_gap_t;

	class gap_board;
		day_gap_t    gap_q[$];
		int unsigned checked;
		int unsigned errors;

		function int unsigned days_in(input int unsigned mon, input bit leap);
			case (mon)
				4, 6, 9, 11: return 30;
				2:           return leap ? 29 : 28;
				default:     return 31;
			endcase
		endfunction

		function longint day_count(input year_t y, input logic signed [7:0] m,
			input logic signed [7:0] d);
			int unsigned yy;
			int          mon;
			int          dd;
			int unsigned doy;
			bit          leap;
			yy = y;
			if (yy > MAX_YEAR)
				yy = MAX_YEAR;
			mon = m;
			if (mon > 12)
				mon = 12;
			else if (mon < 1)
				mon = 1;
			leap = (yy % 400 == 0) || ((yy % 4 == 0) && (yy % 100 != 0));
			dd = d;
			if (dd < 1)
				dd = 1;
			else if (dd > int'(days_in(mon, leap)))
				dd = days_in(mon, leap);
			doy = dd - 1;
			for (int k = 1; k < mon; k++)
				doy += days_in(k, leap);
			return longint'(yy) * 365 + (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400
				+ doy;
		endfunction

		function day_gap_t predict_gap(input date_pair_t p);
			day_gap_t g;
			longint   diff;
			diff = day_count(p.year_a, p.month_a, p.day_a)
				- day_count(p.year_b, p.month_b, p.day_b);
			g.signed_days = diff[DIFF_W-1:0];
			g.abs_days    = (diff < 0) ? DN_W'(-diff) : DN_W'(diff);
			g.a_earlier   = (diff < 0);
			return g;
		endfunction

		function void note_pair(input date_pair_t p);
			gap_q.push_back(predict_gap(p));
		endfunction

		function int unsigned pending();
			return gap_q.size();
		endfunction

		function void check_gap(input day_gap_t got);
			day_gap_t want;
			if (gap_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result signed=%0d abs=%0d earlier=%0b",
						$realtime, got.signed_days, got.abs_days, got.a_earlier);
				return;
			end
			want = gap_q.pop_front();
			checked++;
			if (got.signed_days !== want.signed_days || got.abs_days !== want.abs_days ||
				got.a_earlier !== want.a_earlier) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch expected %0d/%0d/%0b got %0d/%0d/%0b",
						$realtime, want.signed_days, want.abs_days, want.a_earlier,
						got.signed_days, got.abs_days, got.a_earlier);
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	year_t                    year_a;
	logic signed [7:0]        month_a;
	logic signed [7:0]        day_a;
	year_t                    year_b;
	logic signed [7:0]        month_b;
	logic signed [7:0]        day_b;
	logic                     done;
	logic signed [DIFF_W-1:0] signed_days;
	logic [DN_W-1:0]          abs_days;
	logic                     a_earlier;

	gap_board    sb = new;
	int unsigned quiet_cycles;
	int unsigned pairs_sent;
	int unsigned directed_sent;

	date_difference_in_days_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.year_a      (year_a),
		.month_a     (month_a),
		.day_a       (day_a),
		.year_b      (year_b),
		.month_b     (month_b),
		.day_b       (day_b),
		.done        (done),
		.signed_days (signed_days),
		.abs_days    (abs_days),
		.a_earlier   (a_earlier)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_pair('{year_a, month_a, day_a, year_b, month_b, day_b});
			if (done)
				sb.check_gap('{signed_days, abs_days, a_earlier});
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_pair(input date_pair_t p);
		start   <= 1'b1;
		year_a  <= p.year_a;
		month_a <= p.month_a;
		day_a   <= p.day_a;
		year_b  <= p.year_b;
		month_b <= p.month_b;
		day_b   <= p.day_b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pairs_sent++;
	endtask

	task automatic send_dates(input int ya, input int ma, input int da, input int yb,
		input int mb, input int db);
		send_pair('{year_t'(ya), 8'(ma), 8'(da), year_t'(yb), 8'(mb), 8'(db)});
		directed_sent++;
	endtask

	task automatic hold_sender(input int unsigned pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	function automatic date_pair_t rand_pair();
		date_pair_t  p;
		int unsigned kind;
		kind = $urandom_range(9);
		p.year_a  = year_t'($urandom_range(9999));
		p.month_a = 8'($urandom_range(1, 12));
		p.day_a   = 8'($urandom_range(1, 31));
		p.year_b  = year_t'($urandom_range(9999));
		p.month_b = 8'($urandom_range(1, 12));
		p.day_b   = 8'($urandom_range(1, 31));
		case (kind)
			6, 7: begin
				p.year_a  = year_t'($urandom);
				p.month_a = 8'($urandom);
				p.day_a   = 8'($urandom);
				p.year_b  = year_t'($urandom);
				p.month_b = 8'($urandom);
				p.day_b   = 8'($urandom);
			end
			8: begin
				p.year_b  = p.year_a + year_t'($urandom_range(1)) - year_t'($urandom_range(1));
				p.month_b = p.month_a + 8'($urandom_range(2)) - 8'sd1;
				p.day_b   = p.day_a + 8'($urandom_range(6)) - 8'sd3;
			end
			9: begin
				p.year_b  = p.year_a;
				p.month_b = p.month_a;
				p.day_b   = p.day_a;
			end
			default: ;
		endcase
		return p;
	endfunction

	initial begin
		int unsigned idle_pct[3];
		idle_pct = '{20, 69, 0};
		arst_n  = 1'b0;
		start   = 1'b0;
		year_a  = '0;
		month_a = '0;
		day_a   = '0;
		year_b  = '0;
		month_b = '0;
		day_b   = '0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_dates(0, 1, 1, 0, 1, 1);
		send_dates(9999, 12, 31, 0, 1, 1);
		send_dates(0, 1, 1, 9999, 12, 31);
		send_dates(16383, 127, 127, 0, -128, -128);
		send_dates(10000, 0, 0, 9999, 1, 1);
		send_dates(2000, 2, 29, 2000, 3, 1);
		send_dates(1900, 2, 29, 1900, 3, 1);
		send_dates(2024, 2, 30, 2023, 2, 30);
		send_dates(0, 2, 29, 0, 3, 1);
		send_dates(2023, 13, 32, 2023, 12, 31);
		send_dates(2023, -1, -5, 2022, 12, 31);
		send_dates(2021, 4, 31, 2021, 5, 1);
		send_dates(1, 1, 1, 0, 12, 31);
		send_dates(8192, 6, 15, 4096, 6, 15);
		send_dates(5461, -86, 85, 10922, 85, -86);
		send_dates(400, 2, 29, 100, 2, 29);
		send_dates(2024, 12, 31, 2024, 1, 1);
		send_dates(1999, 12, 31, 2000, 1, 1);
		drain_results();

		for (int ph = 0; ph < 3; ph++) begin
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_pair(rand_pair());
				hold_sender(idle_pct[ph]);
			end
			drain_results();
		end

		repeat (20)
			@(posedge clk);
		$display("Covered %0d date pairs (%0d directed) at sender idle rates of 20, 69 and 0 percent",
			pairs_sent, directed_sent);
		$display("Checked %0d results, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ddd_pkg.sv
rtl/ddd_day_number.sv
rtl/date_difference_in_days_top.sv
bench/tb.sv
